### hw/rtl/acss_pkg.sv
// Shared constants, codes and transaction types of the ANSI CSI sequence stripper.
package acss_pkg;

    // Longest sequence that is held back, final byte included.
    localparam int MAX_SEQ = 32;
    localparam int CNT_W   = $clog2(MAX_SEQ + 1);
    localparam int IDX_W   = $clog2(MAX_SEQ);

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] CSI_OPEN = 8'h5B;

    // Scanner modes.
    localparam logic [1:0] MODE_GROUND = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_PARAM  = 2'd2;
    localparam logic [1:0] MODE_INTER  = 2'd3;

    // What follows the replay of held bytes.
    localparam logic [1:0] TAIL_NONE     = 2'd0;
    localparam logic [1:0] TAIL_EMIT     = 2'd1;
    localparam logic [1:0] TAIL_END      = 2'd2;
    localparam logic [1:0] TAIL_HOLD_ESC = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_marker;
        logic       last;
    } t_out_item;

    // Decision taken for one accepted input transaction.
    typedef struct packed {
        logic [CNT_W-1:0] flush_len;
        logic [1:0]       tail;
        logic             wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [1:0]       new_mode;
        logic [CNT_W-1:0] new_count;
    } t_scan_act;

endpackage

### hw/rtl/acss_scan.sv
// Byte classifier and decision logic for one input transaction of the stripper.
module acss_scan (
    input  logic [1:0]                  i_mode,
    input  logic [acss_pkg::CNT_W-1:0]  i_count,
    input  acss_pkg::t_in_item          i_item,
    output acss_pkg::t_scan_act         o_act
);
    import acss_pkg::*;

    localparam logic [CNT_W-1:0] LAST_HOLD = CNT_W'(MAX_SEQ - 1);
    localparam logic [CNT_W-1:0] FULL_LEN  = CNT_W'(MAX_SEQ);

    logic [7:0] b;
    logic       is_param;
    logic       is_inter;
    logic       is_final;
    t_scan_act  hold_act;
    t_scan_act  break_act;

    assign b        = i_item.in_byte;
    assign is_param = b inside {[8'h30:8'h3F]};
    assign is_inter = b inside {[8'h20:8'h2F]};
    assign is_final = b inside {[8'h40:8'h7F]};

    // Hold the byte at the next free place; the place that fills the buffer
    // replays the whole buffer and returns to ground.
    always_comb begin
        hold_act           = '0;
        hold_act.wr_en     = 1'b1;
        hold_act.wr_idx    = i_count[IDX_W-1:0];
        hold_act.tail      = TAIL_NONE;
        if (i_count == LAST_HOLD) begin
            hold_act.flush_len = FULL_LEN;
            hold_act.new_mode  = MODE_GROUND;
            hold_act.new_count = '0;
        end else begin
            hold_act.flush_len = '0;
            hold_act.new_mode  = i_mode;
            hold_act.new_count = i_count + 1'b1;
        end
    end

    // A broken sequence replays its held bytes, then the byte is scanned from ground.
    always_comb begin
        break_act           = '0;
        break_act.flush_len = i_count;
        if (b == ESC_BYTE) begin
            break_act.tail      = TAIL_HOLD_ESC;
            break_act.new_mode  = MODE_ESC;
            break_act.new_count = CNT_W'(1);
        end else begin
            break_act.tail      = TAIL_EMIT;
            break_act.new_mode  = MODE_GROUND;
            break_act.new_count = '0;
        end
    end

    // Main decision.
    always_comb begin
        o_act = '0;
        if (i_item.end_of_text) begin
            o_act.flush_len = i_count;
            o_act.tail      = TAIL_END;
            o_act.new_mode  = MODE_GROUND;
            o_act.new_count = '0;
        end else begin
            case (i_mode)
                MODE_GROUND: begin
                    if (b == ESC_BYTE) begin
                        o_act.wr_en     = 1'b1;
                        o_act.wr_idx    = '0;
                        o_act.tail      = TAIL_NONE;
                        o_act.new_mode  = MODE_ESC;
                        o_act.new_count = CNT_W'(1);
                    end else begin
                        o_act.tail      = TAIL_EMIT;
                        o_act.new_mode  = MODE_GROUND;
                        o_act.new_count = '0;
                    end
                end
                MODE_ESC: begin
                    if (b == CSI_OPEN) begin
                        o_act          = hold_act;
                        o_act.new_mode = (hold_act.flush_len != '0) ? MODE_GROUND : MODE_PARAM;
                    end else begin
                        o_act = break_act;
                    end
                end
                MODE_PARAM: begin
                    if (is_param) begin
                        o_act = hold_act;
                    end else if (is_inter) begin
                        o_act          = hold_act;
                        o_act.new_mode = (hold_act.flush_len != '0) ? MODE_GROUND : MODE_INTER;
                    end else if (is_final) begin
                        o_act.tail      = TAIL_NONE;
                        o_act.new_mode  = MODE_GROUND;
                        o_act.new_count = '0;
                    end else begin
                        o_act = break_act;
                    end
                end
                default: begin
                    if (is_inter) begin
                        o_act = hold_act;
                    end else if (is_final) begin
                        o_act.tail      = TAIL_NONE;
                        o_act.new_mode  = MODE_GROUND;
                        o_act.new_count = '0;
                    end else begin
                        o_act = break_act;
                    end
                end
            endcase
        end
    end

endmodule

### hw/rtl/acss_replay.sv
// Pending byte buffer, replay sequencer and output register of the stripper.
module acss_replay (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_start,
    input  acss_pkg::t_scan_act         i_act,
    input  logic [7:0]                  i_byte,
    output logic                        o_busy,
    output logic                        o_valid,
    input  logic                        i_stall,
    output acss_pkg::t_out_item         o_data
);
    import acss_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic [7:0]       r_buf [MAX_SEQ];
    logic             r_state, n_state;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_len, n_len;
    logic [1:0]       r_tail, n_tail;
    logic [7:0]       r_tail_byte, n_tail_byte;
    logic             r_ov, n_ov;
    t_out_item        r_out, n_out;

    logic             out_free;
    logic             in_replay;
    logic             replay_last;
    logic             tail_emits;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [7:0]       wr_byte;

    assign out_free    = !r_ov || !i_stall;
    assign in_replay   = (r_idx != r_len);
    assign tail_emits  = (r_tail == TAIL_EMIT) || (r_tail == TAIL_END);
    assign replay_last = (r_idx == r_len - 1'b1) && !tail_emits;

    // Sequencer: one held byte per free output slot, then the tail.
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_len       = r_len;
        n_tail      = r_tail;
        n_tail_byte = r_tail_byte;
        n_ov        = r_ov;
        n_out       = r_out;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        wr_idx      = '0;
        wr_byte     = i_byte;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        if (r_state == ST_IDLE) begin
            // Every accepted transaction that holds a byte stores it, results or not.
            wr_en  = i_act.wr_en && i_accept;
            wr_idx = i_act.wr_idx;
            if (i_start) begin
                n_state     = ST_RUN;
                n_idx       = '0;
                n_len       = i_act.flush_len;
                n_tail      = i_act.tail;
                n_tail_byte = i_byte;
            end
        end else if (out_free) begin
            n_ov = 1'b1;
            if (in_replay) begin
                rd_en            = 1'b1;
                n_out.end_marker = 1'b0;
                n_out.last       = replay_last;
                n_idx            = r_idx + 1'b1;
                if (replay_last) begin
                    n_state = ST_IDLE;
                    // A breaking ESC starts a new sequence once the old one is out.
                    if (r_tail == TAIL_HOLD_ESC) begin
                        wr_en   = 1'b1;
                        wr_idx  = '0;
                        wr_byte = ESC_BYTE;
                    end
                end
            end else begin
                n_out.out_byte   = (r_tail == TAIL_END) ? 8'h00 : r_tail_byte;
                n_out.end_marker = (r_tail == TAIL_END);
                n_out.last       = 1'b1;
                n_state          = ST_IDLE;
            end
        end
    end

    // Pending byte store.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[wr_idx] <= wr_byte;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    // Payload registers; a replayed byte is read from the store straight into the output.
    always_ff @(posedge i_clk) begin
        r_idx            <= n_idx;
        r_len            <= n_len;
        r_tail           <= n_tail;
        r_tail_byte      <= n_tail_byte;
        r_out.end_marker <= n_out.end_marker;
        r_out.last       <= n_out.last;
        if (rd_en) begin
            r_out.out_byte <= r_buf[r_idx[IDX_W-1:0]];
        end else begin
            r_out.out_byte <= n_out.out_byte;
        end
    end

    assign o_busy  = (r_state == ST_RUN);
    assign o_valid = r_ov;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_idx <= r_len))
        else $error("replay index ran past the replay length");

    a_len_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_len <= CNT_W'(MAX_SEQ)))
        else $error("replay length exceeds the buffer depth");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("transaction started while the replay was busy");

    a_tail_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && out_free && !in_replay) |=> (r_state == ST_IDLE) && r_ov)
        else $error("tail result did not close the run");

    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_RUN) && out_free) |=> (r_out.last == (r_state == ST_IDLE)))
        else $error("last flag out of step with the end of the run");
`endif

endmodule

### hw/rtl/ansi_csi_sequence_stripper.sv
// Top level of the ANSI CSI sequence stripper: scanner state and channel handshake.
// Path: a plain byte, or an end marker with nothing held, goes into the sequencer's tail
// register, then into the output register. The input stalls while the sequencer is busy; a
// transaction that causes no result is taken without a stall. A flush replays the held bytes,
// then any byte or end marker that follows, at one pending buffer read per unstalled cycle.
// Reset (synchronous, active low) returns the scanner to ground with no bytes held.
module ansi_csi_sequence_stripper (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  acss_pkg::t_in_item    i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output acss_pkg::t_out_item   o_data
);
    import acss_pkg::*;

    logic [1:0]       r_mode, n_mode;
    logic [CNT_W-1:0] r_count, n_count;
    t_scan_act        act;
    logic             busy;
    logic             accept;
    logic             start;

    assign o_stall = busy;
    assign accept  = i_valid && !busy;
    // Only transactions that produce results hand work to the sequencer.
    assign start   = accept && ((act.flush_len != '0) || (act.tail != TAIL_NONE));

    acss_scan u_scan (
        .i_mode  (r_mode),
        .i_count (r_count),
        .i_item  (i_data),
        .o_act   (act)
    );

    acss_replay u_replay (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_start  (start),
        .i_act    (act),
        .i_byte   (i_data.in_byte),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_data   (o_data)
    );

    // Scanner state advances once per accepted transaction.
    always_comb begin
        n_mode  = r_mode;
        n_count = r_count;
        if (accept) begin
            n_mode  = act.new_mode;
            n_count = act.new_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_GROUND;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_count <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(MAX_SEQ))
        else $error("held byte count reached the buffer depth");

    a_ground_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_GROUND) |-> (r_count == '0))
        else $error("bytes held while scanning from ground");

    a_seq_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_GROUND) |-> (r_count != '0))
        else $error("sequence in progress with nothing held");

    a_eot_ground: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.end_of_text) |=> (r_mode == MODE_GROUND) && busy)
        else $error("end of text did not return the scanner to ground");
`endif

endmodule

### test/ansi_csi_sequence_stripper_test.sv
// Self-checking testbench of the ANSI CSI sequence stripper: directed and random text streams.
module ansi_csi_sequence_stripper_test;
    timeunit 1ns;
    timeprecision 1ps;

    import acss_pkg::*;

    // Byte classes of a CSI sequence.
    localparam logic [7:0] PARAM_LO = 8'h30;
    localparam logic [7:0] PARAM_HI = 8'h3F;
    localparam logic [7:0] INTER_LO = 8'h20;
    localparam logic [7:0] INTER_HI = 8'h2F;
    localparam logic [7:0] FINAL_LO = 8'h40;
    localparam logic [7:0] FINAL_HI = 8'h7F;
    localparam logic [7:0] HIGH_BYTE = 8'h80;

    localparam int RESET_CYCLES = 9;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = MAX_SEQ + 8;
    localparam int MAX_PRINTED  = 40;
    localparam int PHASE_ITEMS  = 25;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_item   i_data;
    logic       o_valid;
    logic       i_stall;
    t_out_item  o_data;

    // Scanner state of the prediction.
    logic [1:0] scan_state;
    logic [7:0] held_seq [MAX_SEQ];
    int         held_len;

    t_out_item  stripped_text [$];

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    int results_checked;
    int seqs_removed;
    int texts_closed;
    int error_count;
    int idle_cycles;

    ansi_csi_sequence_stripper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // Clock with a 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Appends one byte of stripped text to the expected stream.
    function automatic void put_text(logic [7:0] b, logic end_mark);
        t_out_item r;
        r.out_byte   = b;
        r.end_marker = end_mark;
        r.last       = 1'b0;
        stripped_text.push_back(r);
    endfunction

    // Replays every held byte as text and returns to ground.
    function automatic void replay_held();
        for (int i = 0; i < held_len && i < MAX_SEQ; i++) begin
            put_text(held_seq[i], 1'b0);
        end
        held_len   = 0;
        scan_state = MODE_GROUND;
    endfunction

    // Holds a sequence byte; a sequence that reaches the limit cannot end, so it is replayed.
    function automatic void hold_seq_byte(logic [7:0] b);
        if (held_len < MAX_SEQ) begin
            held_seq[held_len] = b;
        end
        held_len++;
        if (held_len >= MAX_SEQ) begin
            replay_held();
        end
    endfunction

    function automatic void scan_at_ground(logic [7:0] b);
        if (b == ESC_BYTE) begin
            held_len   = 0;
            scan_state = MODE_ESC;
            hold_seq_byte(b);
        end else begin
            put_text(b, 1'b0);
        end
    endfunction

    // Works out the stripped text caused by one accepted transaction.
    function automatic void strip_predict(t_in_item it);
        int         first_new;
        logic       taken;
        logic [7:0] b;
        t_out_item  tail_item;
        first_new = stripped_text.size();
        taken     = 1'b0;
        b         = it.in_byte;
        if (it.end_of_text) begin
            replay_held();
            put_text(8'h00, 1'b1);
            texts_closed++;
        end else begin
            case (scan_state)
                MODE_ESC: begin
                    if (b == CSI_OPEN) begin
                        scan_state = MODE_PARAM;
                        hold_seq_byte(b);
                        taken = 1'b1;
                    end
                end
                MODE_PARAM: begin
                    if (b >= PARAM_LO && b <= PARAM_HI) begin
                        hold_seq_byte(b);
                        taken = 1'b1;
                    end else if (b >= INTER_LO && b <= INTER_HI) begin
                        scan_state = MODE_INTER;
                        hold_seq_byte(b);
                        taken = 1'b1;
                    end else if (b >= FINAL_LO && b <= FINAL_HI) begin
                        held_len   = 0;
                        scan_state = MODE_GROUND;
                        seqs_removed++;
                        taken = 1'b1;
                    end
                end
                MODE_INTER: begin
                    if (b >= INTER_LO && b <= INTER_HI) begin
                        hold_seq_byte(b);
                        taken = 1'b1;
                    end else if (b >= FINAL_LO && b <= FINAL_HI) begin
                        held_len   = 0;
                        scan_state = MODE_GROUND;
                        seqs_removed++;
                        taken = 1'b1;
                    end
                end
                default: begin
                    scan_at_ground(b);
                    taken = 1'b1;
                end
            endcase
            // A byte that breaks the sequence releases it and is scanned again.
            if (!taken) begin
                replay_held();
                scan_at_ground(b);
            end
        end
        if (stripped_text.size() > first_new) begin
            tail_item      = stripped_text.pop_back();
            tail_item.last = 1'b1;
            stripped_text.push_back(tail_item);
        end
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("Mismatch at %0t ns, result %0d: %s is 0x%02h, expected 0x%02h",
                     $time, results_checked, what, got, want);
        end
    endtask

    // Offers one transaction after a random gap and waits until it is taken.
    task automatic send_item(logic [7:0] b, logic eot);
        t_in_item it;
        it.in_byte     = b;
        it.end_of_text = eot;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid            = 1'b0;
            i_data.in_byte     = 8'($urandom_range(255));
            i_data.end_of_text = 1'($urandom_range(1));
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = it;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        items_sent++;
        strip_predict(it);
        @(negedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(b, 1'b0);
    endtask

    // The text byte is ignored on an end of text, so it is random.
    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // Sends the opening of a sequence: ESC, '[' and random parameter and intermediate bytes.
    task automatic send_csi_body(int n_param, int n_inter);
        send_byte(ESC_BYTE);
        send_byte(CSI_OPEN);
        repeat (n_param) send_byte(8'($urandom_range(PARAM_HI, PARAM_LO)));
        repeat (n_inter) send_byte(8'($urandom_range(INTER_HI, INTER_LO)));
    endtask

    // Receiver stall, redrawn each cycle.
    always @(negedge i_clk) begin
        i_stall = ($urandom_range(99) < recv_idle_pct);
    end

    // Compares each taken result with the oldest expected byte of stripped text.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (stripped_text.size() == 0) begin
                report_mismatch("unexpected result, out_byte", o_data.out_byte, 8'h00);
            end else begin
                want = stripped_text.pop_front();
                if (o_data.out_byte !== want.out_byte) begin
                    report_mismatch("out_byte", o_data.out_byte, want.out_byte);
                end
                if (o_data.end_marker !== want.end_marker) begin
                    report_mismatch("end_marker", 8'(o_data.end_marker), 8'(want.end_marker));
                end
                if (o_data.last !== want.last) begin
                    report_mismatch("last", 8'(o_data.last), 8'(want.last));
                end
            end
            results_checked++;
        end
    end

    // Ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, stripped_text.size());
            $display("ansi_csi_sequence_stripper_test: FAIL");
            $finish;
        end
    end

    // Plain text at the extremes of the byte range passes unchanged.
    task automatic test_plain_text();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h41);
        send_byte(FINAL_HI);
    endtask

    // Complete sequences, with the bounds of every byte class, vanish.
    task automatic test_complete_sequences();
        send_byte(ESC_BYTE);
        send_byte(CSI_OPEN);
        send_byte(PARAM_LO);
        send_byte(PARAM_HI);
        send_byte(INTER_LO);
        send_byte(INTER_HI);
        send_byte(FINAL_LO);
        send_byte(ESC_BYTE);
        send_byte(CSI_OPEN);
        send_byte(FINAL_HI);
        send_byte(8'h58);
    endtask

    // Broken sequences are replayed and the breaking byte scanned again.
    task automatic test_broken_sequences();
        // ESC not followed by '['.
        send_byte(ESC_BYTE);
        send_byte(8'h78);
        // ESC after ESC starts a fresh sequence, which then completes.
        send_byte(ESC_BYTE);
        send_byte(ESC_BYTE);
        send_byte(CSI_OPEN);
        send_byte(8'h6D);
        // A high byte inside the parameters.
        send_csi_body(1, 0);
        send_byte(HIGH_BYTE);
        // A parameter byte after an intermediate.
        send_csi_body(0, 1);
        send_byte(PARAM_LO);
        // An ESC inside the intermediates opens a new sequence.
        send_csi_body(1, 1);
        send_byte(ESC_BYTE);
        send_byte(CSI_OPEN);
        send_byte(FINAL_LO);
        // A control byte below the intermediate class.
        send_csi_body(1, 0);
        send_byte(8'h1F);
    endtask

    // The longest sequence that fits is removed; one byte more is replayed as text.
    task automatic test_overlong_sequence();
        send_csi_body(MAX_SEQ - 3, 0);
        send_byte(FINAL_LO);
        send_csi_body(MAX_SEQ - 2, 0);
        send_byte(FINAL_HI);
        send_csi_body(MAX_SEQ - 4, 2);
        send_byte(FINAL_LO);
    endtask

    // End of text at ground, after a lone ESC and inside a sequence.
    task automatic test_end_of_text();
        send_end();
        send_byte(ESC_BYTE);
        send_item(ESC_BYTE, 1'b1);
        send_csi_body(2, 1);
        send_end();
        send_end();
    endtask

    // Random text: plain bytes, complete sequences, broken ones, a few long ones and ends of text.
    task automatic test_random_text(int n_items);
        int first_item;
        int pick;
        first_item = items_sent;
        while (items_sent - first_item < n_items) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_byte(8'($urandom_range(255)));
            end else if (pick < 68) begin
                send_csi_body($urandom_range(4), $urandom_range(2));
                send_byte(8'($urandom_range(FINAL_HI, FINAL_LO)));
            end else if (pick < 75) begin
                send_byte(ESC_BYTE);
                send_byte(8'($urandom_range(255)));
            end else if (pick < 88) begin
                send_csi_body($urandom_range(3), $urandom_range(2));
                send_byte(8'($urandom_range(255)));
            end else if (pick < 92) begin
                send_csi_body($urandom_range(MAX_SEQ - 2, MAX_SEQ - 5), $urandom_range(1));
                send_byte(8'($urandom_range(FINAL_HI, FINAL_LO)));
            end else if (pick < 96) begin
                send_csi_body($urandom_range(2), $urandom_range(1));
                send_end();
            end else begin
                send_end();
            end
        end
    endtask

    // Test sequence: reset, directed tests, then random text under three idling patterns.
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        i_stall       = 1'b0;
        scan_state    = MODE_GROUND;
        held_len      = 0;
        send_idle_pct = 19;
        recv_idle_pct = 83;
        items_sent      = 0;
        results_checked = 0;
        seqs_removed    = 0;
        texts_closed    = 0;
        error_count     = 0;
        idle_cycles     = 0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_plain_text();
        test_complete_sequences();
        test_broken_sequences();
        test_overlong_sequence();
        test_end_of_text();
        test_random_text(PHASE_ITEMS);
        send_idle_pct = 83;
        recv_idle_pct = 19;
        test_random_text(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_text(PHASE_ITEMS);
        i_valid = 1'b0;

        // Let the last held bytes drain, then watch for stray results.
        while (stripped_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d input transactions; checked %0d results, %0d errors.",
                 items_sent, results_checked, error_count);
        $display("Covered %0d removed sequences and %0d closed texts.",
                 seqs_removed, texts_closed);
        if (error_count == 0) begin
            $display("ansi_csi_sequence_stripper_test: PASS");
        end else begin
            $display("ansi_csi_sequence_stripper_test: FAIL");
        end
        $finish;
    end

endmodule
